>>> hdl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the identity digest accumulator.
// ----------------------------------------------------------------------------
package ids_pkg;

  // Step counter width: the control program holds 35 words.
  localparam int unsigned PcW = 6;

  // Mixer constants
  localparam logic [63:0] MixBias     = 64'hD1B54A32D192ED03;
  localparam logic [63:0] MixMul      = 64'h9FB21C651E98DF25;
  localparam logic [63:0] SaltFeed    = 64'hC3A5C85C97CB3127;
  localparam logic [63:0] SaltMissing = 64'hDB4F0B9175AE2165;
  localparam logic [63:0] SaltScrub   = 64'hA0761D6478BD642F;

  // Working register operation
  typedef enum logic [2:0] {
    X_HOLD,   // keep
    X_LOAD,   // load operand picked by ld
    X_PRE,    // xor salt, rotl 19, add bias, xorshift 37
    X_ROT,    // product ^ rotl(product, 23)
    X_SH,     // product ^ (product >> 29)
    X_OR1     // force bit 0
  } xop_e;

  // Load operand
  typedef enum logic [1:0] {
    LD_FEED,  // (acc + domain) ^ rotl(index, 7) ^ byte
    LD_MISS,  // acc ^ domain ^ mask
    LD_HIT    // acc ^ expected digest
  } ld_e;

  // Partial product step
  typedef enum logic [1:0] {
    P_HOLD,
    P_LL,     // p  = a_lo * b_lo
    P_HL,     // p += (a_hi * b_lo) << 32
    P_LH      // p += (a_lo * b_hi) << 32
  } pop_e;

  // Multiplier constant
  typedef enum logic {
    B_MIX,
    B_SALT
  } bsel_e;

  typedef enum logic [1:0] {
    S_FEED,
    S_MISS,
    S_SCRUB
  } salt_e;

  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_KIND,
    J_SKIP,
    J_DONE,
    J_ENOUGH
  } jmp_e;

  // Side effects on block state
  typedef enum logic [2:0] {
    A_NONE,
    A_CAPTURE,   // latch finish word from the working register
    A_FEED_END,  // commit feed, emit result
    A_FIN_END,   // commit finish, emit result
    A_REPEAT     // emit result of a repeated finish
  } act_e;

  typedef struct packed {
    xop_e             xop;
    ld_e              ld;
    pop_e             pop;
    bsel_e            bsel;
    salt_e            salt;
    jmp_e             jmp;
    logic [PcW-1:0]   target;
    act_e             act;
    logic             last;
  } ctrl_t;

  // Branch conditions and hold request into the sequencer
  typedef struct packed {
    logic kind;
    logic skip;
    logic done;
    logic enough;
    logic stall;
  } flags_t;

endpackage

>>> hdl/identity_digest_accumulator.sv
// ----------------------------------------------------------------------------
// identity_digest_accumulator
// Folds domain-tagged identity bytes into a 64-bit digest and checks it.
// ----------------------------------------------------------------------------
// Each request on the input stream is either a feed (tuser = 0) carrying one
// identity byte and a 64-bit domain, or a finish (tuser = 1). tlast on a feed
// closes one factor's run: it sets mask bit domain[5:0] and clears the byte
// index. Every request gives exactly one result request on the output
// stream. Items are processed one at a time by a small microcoded sequencer
// driving a single shared 32x32 multiplier; each 64-bit constant multiply is
// three partial-product steps, and the mixer needs two of them. Skipped
// (whitespace/NUL) feeds, finishes with enough factors seen and repeated
// finishes take shorter paths through the control program. The input is
// ready again from the edge that loads the result into the output
// register, so a new request is taken only after the previous one has
// reached the output register. The output register lets the next item
// start while a result waits; the sequencer only holds on its final step
// if the previous result is still pending. Configuration writes go
// through cfg_we_i/cfg_idx_i/cfg_data_i and must only be issued while
// the block is idle; writing the seed register reloads the accumulator
// and leaves mask, index and the finished flag untouched.
// ----------------------------------------------------------------------------
module identity_digest_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,

  // config write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,

  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // domain[63:0], data_byte[71:64]
  input  logic         s_axis_tuser,   // kind
  input  logic         s_axis_tlast,   // last_byte

  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata    // accumulator_out[63:0],
                                       // factor_mask_out[127:64],
                                       // contribution[191:128],
                                       // quorum_met[192], finished[193],
                                       // zero fill [199:194]
);

  // register indexes
  localparam logic [1:0] RegExpected = 2'd0;
  localparam logic [1:0] RegMinFact  = 2'd1;
  localparam logic [1:0] RegCanon    = 2'd2;
  localparam logic [1:0] RegSeed     = 2'd3;

  // config registers
  logic [63:0] expected_q;
  logic [3:0]  minf_q;
  logic        canon_q;

  // block state; cnt_q tracks popcount of mask_q
  logic [63:0] acc_q, acc_d;
  logic [63:0] mask_q, mask_d;
  logic [63:0] idx_q, idx_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  // latched request
  logic [63:0] dom_q;
  logic [7:0]  byte_q;
  logic        kind_q;
  logic        last_q;

  // captured finish word
  logic [63:0] c_q;

  // result register
  logic         ovalid_q;
  logic [199:0] odata_q;

  ids_pkg::ctrl_t  ctrl;
  ids_pkg::flags_t flags;
  logic            busy;
  logic            start;
  logic            fire;
  logic            stall;
  logic [63:0]     x;
  logic [63:0]     ld;

  logic        ws, upper, use_byte;
  logic [7:0]  byte_c;
  logic [3:0]  need;
  logic        enough_c;
  logic [5:0]  bitpos;
  logic        newbit;
  logic [63:0] fin_contrib;
  logic        fin_enough;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;

  // hold the final step while the previous result is still pending
  assign stall = ctrl.last && ovalid_q && !m_axis_tready;
  assign fire  = busy && ctrl.last && !stall;

  // byte canonicalization
  assign ws = (byte_q == 8'h20) || (byte_q == 8'h0A) || (byte_q == 8'h0D) ||
              (byte_q == 8'h09) || (byte_q == 8'h00);
  assign upper    = (byte_q >= 8'h41) && (byte_q <= 8'h5A);
  assign use_byte = !(canon_q && ws);
  assign byte_c   = (canon_q && upper) ? (byte_q + 8'd32) : byte_q;

  // minimum factor count, clamped to 1..8
  always_comb begin
    if (minf_q == 4'd0) begin
      need = 4'd1;
    end else if (minf_q > 4'd8) begin
      need = 4'd8;
    end else begin
      need = minf_q;
    end
  end
  assign enough_c = cnt_q >= {3'b000, need};

  assign bitpos = dom_q[5:0];
  assign newbit = !mask_q[bitpos];

  // operand for the working register load
  always_comb begin
    unique case (ctrl.ld)
      ids_pkg::LD_FEED: ld = (acc_q + dom_q) ^ {idx_q[56:0], idx_q[63:57]} ^
                             {56'h0, byte_c};
      ids_pkg::LD_MISS: ld = acc_q ^ dom_q ^ mask_q;
      ids_pkg::LD_HIT:  ld = acc_q ^ expected_q;
      default:          ld = acc_q;
    endcase
  end

  assign flags.kind   = kind_q;
  assign flags.skip   = !use_byte;
  assign flags.done   = done_q;
  assign flags.enough = enough_c;
  assign flags.stall  = stall;

  ids_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ids_mix u_mix (
    .clk_i  (clk_i),
    .en_i   (busy),
    .ctrl_i (ctrl),
    .ld_i   (ld),
    .x_o    (x)
  );

  // state commit on the final step of each program
  always_comb begin
    acc_d       = acc_q;
    mask_d      = mask_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    fin_contrib = 64'h0;
    fin_enough  = 1'b0;
    unique case (ctrl.act)
      ids_pkg::A_FEED_END: begin
        if (use_byte) begin
          acc_d = x;
        end
        if (last_q) begin
          mask_d = mask_q | (64'd1 << bitpos);
          cnt_d  = cnt_q + {6'd0, newbit};
          idx_d  = 64'h0;
        end else begin
          idx_d = idx_q + 64'd1;
        end
      end
      ids_pkg::A_FIN_END: begin
        acc_d       = x;
        mask_d      = 64'h0;
        cnt_d       = 7'd0;
        done_d      = 1'b1;
        fin_contrib = c_q;
        fin_enough  = enough_c;
      end
      default: begin
        // no commit; repeated finish reports state unchanged
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= 64'h0;
      minf_q     <= 4'd1;
      canon_q    <= 1'b1;
      acc_q      <= 64'h0;
      mask_q     <= 64'h0;
      idx_q      <= 64'h0;
      cnt_q      <= 7'd0;
      done_q     <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegExpected: expected_q <= cfg_data_i;
          RegMinFact:  minf_q     <= cfg_data_i[3:0];
          RegCanon:    canon_q    <= cfg_data_i[0];
          RegSeed:     acc_q      <= cfg_data_i;
        endcase
      end else if (fire) begin
        acc_q  <= acc_d;
        mask_q <= mask_d;
        idx_q  <= idx_d;
        cnt_q  <= cnt_d;
        done_q <= done_d;
      end
      if (fire) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      dom_q  <= s_axis_tdata[63:0];
      byte_q <= s_axis_tdata[71:64];
      kind_q <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (busy && (ctrl.act == ids_pkg::A_CAPTURE)) begin
      c_q <= x;
    end
    if (fire) begin
      odata_q <= {6'b000000, done_d, fin_enough, fin_contrib, mask_d, acc_d};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

`ifndef SYNTHESIS
  // mask popcount shadow stays exact
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {25'd0, cnt_q} == 32'($countones(mask_q)))
    else $error("factor count out of step with mask");

  // finished flag is sticky
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(done_q))
    else $error("finished flag dropped");

  // missing-factor finish word is odd
  a_miss_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (ctrl.act == ids_pkg::A_FIN_END) && !enough_c) |-> c_q[0])
    else $error("missing-factor word has bit 0 clear");

  // an accepted request starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("sequencer not busy after request");
`endif

endmodule

>>> hdl/ids_useq.sv
// ----------------------------------------------------------------------------
// ids_useq
// Microcode sequencer: control store, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module ids_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ids_pkg::flags_t flags_i,
  output ids_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);

  localparam logic [ids_pkg::PcW-1:0] StFeedEnd = ids_pkg::PcW'(10);
  localparam logic [ids_pkg::PcW-1:0] StFin     = ids_pkg::PcW'(11);
  localparam logic [ids_pkg::PcW-1:0] StHit     = ids_pkg::PcW'(23);
  localparam logic [ids_pkg::PcW-1:0] StScrub   = ids_pkg::PcW'(24);
  localparam logic [ids_pkg::PcW-1:0] StRepeat  = ids_pkg::PcW'(34);

  function automatic ids_pkg::ctrl_t cw(
    ids_pkg::xop_e             xop,
    ids_pkg::ld_e              ld,
    ids_pkg::pop_e             pop,
    ids_pkg::bsel_e            bsel,
    ids_pkg::salt_e            salt,
    ids_pkg::jmp_e             jmp,
    logic [ids_pkg::PcW-1:0]   tgt,
    ids_pkg::act_e             act,
    logic                      last
  );
    ids_pkg::ctrl_t w;
    w.xop    = xop;
    w.ld     = ld;
    w.pop    = pop;
    w.bsel   = bsel;
    w.salt   = salt;
    w.jmp    = jmp;
    w.target = tgt;
    w.act    = act;
    w.last   = last;
    return w;
  endfunction

  // Plain multiply step
  function automatic ids_pkg::ctrl_t mw(ids_pkg::pop_e pop, ids_pkg::bsel_e bsel,
                                        ids_pkg::salt_e salt);
    return cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, pop, bsel, salt, ids_pkg::J_NONE,
              '0, ids_pkg::A_NONE, 1'b0);
  endfunction

  // Plain working-register step
  function automatic ids_pkg::ctrl_t xw(ids_pkg::xop_e xop, ids_pkg::salt_e salt);
    return cw(xop, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX, salt,
              ids_pkg::J_NONE, '0, ids_pkg::A_NONE, 1'b0);
  endfunction

  function automatic ids_pkg::ctrl_t rom(logic [ids_pkg::PcW-1:0] a);
    ids_pkg::ctrl_t w;
    unique case (a)
      // feed: load, pre-mix (or skip), two 64-bit products, commit
      0:  w = cw(ids_pkg::X_LOAD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_FEED, ids_pkg::J_KIND, StFin, ids_pkg::A_NONE, 1'b0);
      1:  w = cw(ids_pkg::X_PRE, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_FEED, ids_pkg::J_SKIP, StFeedEnd, ids_pkg::A_NONE, 1'b0);
      2:  w = mw(ids_pkg::P_LL, ids_pkg::B_MIX, ids_pkg::S_FEED);
      3:  w = mw(ids_pkg::P_HL, ids_pkg::B_MIX, ids_pkg::S_FEED);
      4:  w = mw(ids_pkg::P_LH, ids_pkg::B_MIX, ids_pkg::S_FEED);
      5:  w = xw(ids_pkg::X_ROT, ids_pkg::S_FEED);
      6:  w = mw(ids_pkg::P_LL, ids_pkg::B_SALT, ids_pkg::S_FEED);
      7:  w = mw(ids_pkg::P_HL, ids_pkg::B_SALT, ids_pkg::S_FEED);
      8:  w = mw(ids_pkg::P_LH, ids_pkg::B_SALT, ids_pkg::S_FEED);
      9:  w = xw(ids_pkg::X_SH, ids_pkg::S_FEED);
      10: w = cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_FEED, ids_pkg::J_NONE, '0, ids_pkg::A_FEED_END, 1'b1);
      // finish: repeated check, then hit or missing-factor word
      11: w = cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_MISS, ids_pkg::J_DONE, StRepeat, ids_pkg::A_NONE, 1'b0);
      12: w = cw(ids_pkg::X_LOAD, ids_pkg::LD_MISS, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_MISS, ids_pkg::J_ENOUGH, StHit, ids_pkg::A_NONE, 1'b0);
      13: w = xw(ids_pkg::X_PRE, ids_pkg::S_MISS);
      14: w = mw(ids_pkg::P_LL, ids_pkg::B_MIX, ids_pkg::S_MISS);
      15: w = mw(ids_pkg::P_HL, ids_pkg::B_MIX, ids_pkg::S_MISS);
      16: w = mw(ids_pkg::P_LH, ids_pkg::B_MIX, ids_pkg::S_MISS);
      17: w = xw(ids_pkg::X_ROT, ids_pkg::S_MISS);
      18: w = mw(ids_pkg::P_LL, ids_pkg::B_SALT, ids_pkg::S_MISS);
      19: w = mw(ids_pkg::P_HL, ids_pkg::B_SALT, ids_pkg::S_MISS);
      20: w = mw(ids_pkg::P_LH, ids_pkg::B_SALT, ids_pkg::S_MISS);
      21: w = xw(ids_pkg::X_SH, ids_pkg::S_MISS);
      22: w = cw(ids_pkg::X_OR1, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_MISS, ids_pkg::J_ALWAYS, StScrub, ids_pkg::A_NONE, 1'b0);
      23: w = cw(ids_pkg::X_LOAD, ids_pkg::LD_HIT, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_SCRUB, ids_pkg::J_NONE, '0, ids_pkg::A_NONE, 1'b0);
      // scrub: finish word is in the working register on entry
      24: w = cw(ids_pkg::X_PRE, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_SCRUB, ids_pkg::J_NONE, '0, ids_pkg::A_CAPTURE, 1'b0);
      25: w = mw(ids_pkg::P_LL, ids_pkg::B_MIX, ids_pkg::S_SCRUB);
      26: w = mw(ids_pkg::P_HL, ids_pkg::B_MIX, ids_pkg::S_SCRUB);
      27: w = mw(ids_pkg::P_LH, ids_pkg::B_MIX, ids_pkg::S_SCRUB);
      28: w = xw(ids_pkg::X_ROT, ids_pkg::S_SCRUB);
      29: w = mw(ids_pkg::P_LL, ids_pkg::B_SALT, ids_pkg::S_SCRUB);
      30: w = mw(ids_pkg::P_HL, ids_pkg::B_SALT, ids_pkg::S_SCRUB);
      31: w = mw(ids_pkg::P_LH, ids_pkg::B_SALT, ids_pkg::S_SCRUB);
      32: w = xw(ids_pkg::X_SH, ids_pkg::S_SCRUB);
      33: w = cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_SCRUB, ids_pkg::J_NONE, '0, ids_pkg::A_FIN_END, 1'b1);
      34: w = cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                 ids_pkg::S_SCRUB, ids_pkg::J_NONE, '0, ids_pkg::A_REPEAT, 1'b1);
      // unused words drop back to idle
      default: w = cw(ids_pkg::X_HOLD, ids_pkg::LD_FEED, ids_pkg::P_HOLD, ids_pkg::B_MIX,
                      ids_pkg::S_FEED, ids_pkg::J_NONE, '0, ids_pkg::A_NONE, 1'b1);
    endcase
    return w;
  endfunction

  logic [ids_pkg::PcW-1:0] pc_q;
  logic                    busy_q;
  ids_pkg::ctrl_t          ctrl;
  logic                    take;

  assign ctrl   = rom(pc_q);
  assign ctrl_o = ctrl;
  assign busy_o = busy_q;

  always_comb begin
    unique case (ctrl.jmp)
      ids_pkg::J_NONE:   take = 1'b0;
      ids_pkg::J_ALWAYS: take = 1'b1;
      ids_pkg::J_KIND:   take = flags_i.kind;
      ids_pkg::J_SKIP:   take = flags_i.skip;
      ids_pkg::J_DONE:   take = flags_i.done;
      ids_pkg::J_ENOUGH: take = flags_i.enough;
      default:           take = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (busy_q && !flags_i.stall) begin
      if (ctrl.last) begin
        busy_q <= 1'b0;
        pc_q   <= '0;
      end else if (take) begin
        pc_q <= ctrl.target;
      end else begin
        pc_q <= pc_q + ids_pkg::PcW'(1);
      end
    end
  end

endmodule

>>> hdl/ids_mix.sv
// ----------------------------------------------------------------------------
// ids_mix
// Mixer datapath: working register, product register, one 32x32 multiplier.
// ----------------------------------------------------------------------------
module ids_mix (
  input  logic           clk_i,
  input  logic           en_i,
  input  ids_pkg::ctrl_t ctrl_i,
  input  logic [63:0]    ld_i,
  output logic [63:0]    x_o
);

  logic [63:0] x_q, x_d;
  logic [63:0] p_q, p_d;
  logic [63:0] salt, bmul;
  logic [63:0] t, r;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    unique case (ctrl_i.salt)
      ids_pkg::S_FEED:  salt = ids_pkg::SaltFeed;
      ids_pkg::S_MISS:  salt = ids_pkg::SaltMissing;
      ids_pkg::S_SCRUB: salt = ids_pkg::SaltScrub;
      default:          salt = ids_pkg::SaltFeed;
    endcase
  end

  assign bmul = (ctrl_i.bsel == ids_pkg::B_MIX) ? ids_pkg::MixMul : (salt | 64'd1);

  // pre-mix: rotl 19 then bias add
  assign t = x_q ^ salt;
  assign r = {t[44:0], t[63:45]} + ids_pkg::MixBias;

  always_comb begin
    unique case (ctrl_i.pop)
      ids_pkg::P_HL: begin
        ma = x_q[63:32];
        mb = bmul[31:0];
      end
      ids_pkg::P_LH: begin
        ma = x_q[31:0];
        mb = bmul[63:32];
      end
      default: begin
        ma = x_q[31:0];
        mb = bmul[31:0];
      end
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    x_d = x_q;
    p_d = p_q;
    if (en_i) begin
      unique case (ctrl_i.xop)
        ids_pkg::X_HOLD: x_d = x_q;
        ids_pkg::X_LOAD: x_d = ld_i;
        ids_pkg::X_PRE:  x_d = r ^ (r >> 37);
        ids_pkg::X_ROT:  x_d = p_q ^ {p_q[40:0], p_q[63:41]};
        ids_pkg::X_SH:   x_d = p_q ^ (p_q >> 29);
        ids_pkg::X_OR1:  x_d = x_q | 64'd1;
        default:         x_d = x_q;
      endcase
      unique case (ctrl_i.pop)
        ids_pkg::P_HOLD: p_d = p_q;
        ids_pkg::P_LL:   p_d = prod;
        ids_pkg::P_HL,
        ids_pkg::P_LH:   p_d = p_q + {prod[31:0], 32'h0};
        default:         p_d = p_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    p_q <= p_d;
  end

  assign x_o = x_q;

endmodule
